/* hdl/casc_pkg.sv */
// Shared types and constants for the circular stepper axis controller.
// No dependencies; used by every module in hdl/.
package casc_pkg;

  localparam int STEPS_PER_TURN    = 800;
  localparam int HOME_SEARCH_LIMIT = 805;
  localparam int HOME_OVERRUN      = 10;

  localparam int POS_W   = 10;
  localparam int CNT_W   = 10;
  localparam int TIMER_W = 16;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 16;

  localparam logic [TIMER_W-1:0] HALF_PERIOD_RST = 16'd1000;

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [TIMER_W-1:0] timer_t;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_HOME = 2'd2,
    CMD_OFF  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_MOVE_DONE = 2'd1,
    ST_HOME_OK   = 2'd2,
    ST_HOME_FAIL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_MOVE = 3'b010,
    MODE_HOME = 3'b100
  } mode_t;

  typedef struct packed {
    logic end_switch;
    pos_t target;
    cmd_t command;
  } in_item_t;

  typedef struct packed {
    status_t status;
    logic    busy_res;
    pos_t    position;
    logic    driver_on;
    logic    dir_out;
    logic    step_out;
  } result_t;

endpackage

/* hdl/casc_core.sv */
// Axis state registers and the per-tick next-state logic.
// Depends on casc_pkg.
module casc_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  casc_pkg::in_item_t       item,
  input  casc_pkg::timer_t         half_period,
  output casc_pkg::result_t        result
);

  localparam casc_pkg::pos_t LAST_POS  = casc_pkg::POS_W'(casc_pkg::STEPS_PER_TURN - 1);
  localparam casc_pkg::cnt_t TURN      = casc_pkg::CNT_W'(casc_pkg::STEPS_PER_TURN);
  localparam casc_pkg::cnt_t HALF_TURN = casc_pkg::CNT_W'(casc_pkg::STEPS_PER_TURN / 2);
  localparam casc_pkg::cnt_t OVERRUN   = casc_pkg::CNT_W'(casc_pkg::HOME_OVERRUN);
  localparam casc_pkg::cnt_t SEARCH    = casc_pkg::CNT_W'(casc_pkg::HOME_SEARCH_LIMIT);

  casc_pkg::pos_t   position_reg, position_reg_next;
  casc_pkg::mode_t  mode_reg, mode_reg_next;
  casc_pkg::cnt_t   steps_left, steps_left_next;
  casc_pkg::timer_t phase_timer, phase_timer_next;
  logic             pulse_phase, pulse_phase_next;
  logic             direction_reg, direction_reg_next;
  logic             driver_enabled, driver_enabled_next;
  casc_pkg::status_t status;

  casc_pkg::timer_t plen;
  casc_pkg::pos_t   tgt;
  casc_pkg::cnt_t   diff;
  casc_pkg::cnt_t   move_steps;
  logic             move_dir;
  casc_pkg::timer_t timer_dec;
  casc_pkg::pos_t   pos_stepped;
  casc_pkg::cnt_t   steps_dec;

  always_comb begin
    plen = (half_period == '0) ? casc_pkg::TIMER_W'(1) : half_period;
    tgt  = (item.target > LAST_POS) ? LAST_POS : item.target;

    // shorter way round; a tie of half a turn goes the other way
    if (position_reg < tgt) begin
      diff = casc_pkg::CNT_W'(tgt - position_reg);
      move_dir = (diff < HALF_TURN);
    end else begin
      diff = casc_pkg::CNT_W'(position_reg - tgt);
      move_dir = !(diff < HALF_TURN);
    end
    move_steps = (diff < HALF_TURN) ? diff : TURN - diff;

    timer_dec   = (phase_timer != '0) ? phase_timer - 1'b1 : phase_timer;
    steps_dec   = (steps_left != '0) ? steps_left - 1'b1 : steps_left;
    if (direction_reg) begin
      pos_stepped = (position_reg == LAST_POS) ? '0 : position_reg + 1'b1;
    end else begin
      pos_stepped = (position_reg == '0) ? LAST_POS : position_reg - 1'b1;
    end
  end

  always_comb begin
    position_reg_next   = position_reg;
    mode_reg_next       = mode_reg;
    steps_left_next     = steps_left;
    phase_timer_next    = phase_timer;
    pulse_phase_next    = pulse_phase;
    direction_reg_next  = direction_reg;
    driver_enabled_next = driver_enabled;
    status              = casc_pkg::ST_NONE;

    case (item.command)
      casc_pkg::CMD_OFF: begin
        mode_reg_next       = casc_pkg::MODE_IDLE;
        pulse_phase_next    = 1'b0;
        phase_timer_next    = '0;
        steps_left_next     = '0;
        driver_enabled_next = 1'b0;
      end
      casc_pkg::CMD_MOVE: begin
        driver_enabled_next = 1'b1;
        direction_reg_next  = move_dir;
        if (move_steps == '0) begin
          mode_reg_next    = casc_pkg::MODE_IDLE;
          pulse_phase_next = 1'b0;
          phase_timer_next = '0;
          steps_left_next  = '0;
          status           = casc_pkg::ST_MOVE_DONE;
        end else begin
          mode_reg_next    = casc_pkg::MODE_MOVE;
          steps_left_next  = move_steps;
          pulse_phase_next = 1'b1;
          phase_timer_next = plen;
        end
      end
      casc_pkg::CMD_HOME: begin
        if (item.end_switch) begin
          position_reg_next = '0;
          mode_reg_next     = casc_pkg::MODE_IDLE;
          pulse_phase_next  = 1'b0;
          phase_timer_next  = '0;
          steps_left_next   = '0;
          status            = casc_pkg::ST_HOME_OK;
        end else begin
          driver_enabled_next = 1'b1;
          direction_reg_next  = 1'b0;
          steps_left_next     = (position_reg != '0) ?
                                casc_pkg::CNT_W'(position_reg) + OVERRUN : SEARCH;
          mode_reg_next       = casc_pkg::MODE_HOME;
          pulse_phase_next    = 1'b1;
          phase_timer_next    = plen;
        end
      end
      default: begin
        if (mode_reg != casc_pkg::MODE_IDLE) begin
          phase_timer_next = timer_dec;
          if (timer_dec == '0) begin
            if (pulse_phase) begin
              pulse_phase_next = 1'b0;
              phase_timer_next = plen;
            end else begin
              // low phase over: step completes
              position_reg_next = pos_stepped;
              steps_left_next   = steps_dec;
              if (mode_reg == casc_pkg::MODE_HOME && item.end_switch) begin
                position_reg_next   = '0;
                driver_enabled_next = 1'b0;
                mode_reg_next       = casc_pkg::MODE_IDLE;
                pulse_phase_next    = 1'b0;
                phase_timer_next    = '0;
                steps_left_next     = '0;
                status              = casc_pkg::ST_HOME_OK;
              end else if (steps_dec == '0) begin
                status = (mode_reg == casc_pkg::MODE_HOME) ?
                         casc_pkg::ST_HOME_FAIL : casc_pkg::ST_MOVE_DONE;
                mode_reg_next    = casc_pkg::MODE_IDLE;
                pulse_phase_next = 1'b0;
                phase_timer_next = '0;
              end else begin
                pulse_phase_next = 1'b1;
                phase_timer_next = plen;
              end
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_reg   <= '0;
      mode_reg       <= casc_pkg::MODE_IDLE;
      steps_left     <= '0;
      phase_timer    <= '0;
      pulse_phase    <= 1'b0;
      direction_reg  <= 1'b0;
      driver_enabled <= 1'b0;
    end else if (fire) begin
      position_reg   <= position_reg_next;
      mode_reg       <= mode_reg_next;
      steps_left     <= steps_left_next;
      phase_timer    <= phase_timer_next;
      pulse_phase    <= pulse_phase_next;
      direction_reg  <= direction_reg_next;
      driver_enabled <= driver_enabled_next;
    end
  end

  always_comb begin
    result.step_out  = pulse_phase_next;
    result.dir_out   = direction_reg_next;
    result.driver_on = driver_enabled_next;
    result.position  = position_reg_next;
    result.busy_res  = (mode_reg_next != casc_pkg::MODE_IDLE);
    result.status    = status;
  end

endmodule

/* hdl/casc_out_reg.sv */
// Result register on the master side: holds one result until it is taken.
// Depends on casc_pkg.
module casc_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  casc_pkg::result_t  result,
  input  logic               take,
  output logic               full,
  output casc_pkg::result_t  data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

endmodule

/* hdl/circular_axis_stepper_controller.sv */
// Stepper axis controller for a circular track, one input transaction per tick.
// The result is registered and appears in the cycle after the input transaction is accepted.
// Throughput: one transaction per cycle; the state update is a single pass and
// input is taken whenever the result register is empty or being drained.
// Reset (rst, synchronous): position 0, idle, driver off, half period 1000.
module circular_axis_stepper_controller (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [1:0] command, [11:2] target, [12] end_switch, [15:13] zero
  input  logic [casc_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [0] step_out, [1] dir_out, [2] driver_on, [12:3] position,
  // [13] busy_res, [15:14] status
  output logic [casc_pkg::OUT_W-1:0]   m_axis_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [casc_pkg::TIMER_W-1:0] cfg_data
);

  casc_pkg::timer_t   half_period;
  casc_pkg::in_item_t item;
  casc_pkg::result_t  result;
  casc_pkg::result_t  out_data;
  logic               fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= casc_pkg::HALF_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      half_period <= cfg_data;
    end
  end

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign item          = casc_pkg::in_item_t'(s_axis_tdata[$bits(casc_pkg::in_item_t)-1:0]);

  casc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (item),
    .half_period (half_period),
    .result      (result)
  );

  casc_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (fire),
    .result (result),
    .take   (m_axis_tready),
    .full   (m_axis_tvalid),
    .data   (out_data)
  );

  assign m_axis_tdata = casc_pkg::OUT_W'(out_data);

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[12:3] < casc_pkg::POS_W'(casc_pkg::STEPS_PER_TURN)))
    else $error("position out of range");

  a_status_idle: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[15:14] != casc_pkg::ST_NONE) |-> !m_axis_tdata[13])
    else $error("status reported while still busy");

  a_busy_drv: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[13]) |-> m_axis_tdata[2])
    else $error("busy with driver disabled");

  a_accept_out: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_axis_tvalid)
    else $error("accepted transaction produced no result");
`endif

endmodule

/* bench/tb_circular_axis_stepper_controller.sv */
// Self-checking bench for the circular stepper axis controller: tick stream in, one
// status word out per tick, compared against an in-bench model of the axis.
// Depends on hdl/casc_pkg.sv and hdl/circular_axis_stepper_controller.sv.
module tb_circular_axis_stepper_controller;
  timeunit 1ns;
  timeprecision 1ps;

  // Tracks the axis state and holds the status words still owed by the block.
  class axis_step_checker;
    casc_pkg::timer_t  half_period;
    casc_pkg::pos_t    pos;
    casc_pkg::mode_t   mode;
    casc_pkg::cnt_t    steps_left;
    casc_pkg::timer_t  phase_timer;
    logic              pulse_hi;
    logic              dir_cw;
    logic              drv_on;
    casc_pkg::result_t owed_q[$];
    int                errors;
    int                checked;

    function new();
      half_period = casc_pkg::HALF_PERIOD_RST;
      pos         = '0;
      mode        = casc_pkg::MODE_IDLE;
      steps_left  = '0;
      phase_timer = '0;
      pulse_hi    = 1'b0;
      dir_cw      = 1'b0;
      drv_on      = 1'b0;
      errors      = 0;
      checked     = 0;
    endfunction

    function casc_pkg::timer_t phase_len();
      return (half_period == 0) ? casc_pkg::timer_t'(1) : half_period;
    endfunction

    function void go_idle();
      mode        = casc_pkg::MODE_IDLE;
      pulse_hi    = 1'b0;
      phase_timer = '0;
      steps_left  = '0;
    endfunction

    function void start_step();
      pulse_hi    = 1'b1;
      phase_timer = phase_len();
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void set_half_period(casc_pkg::timer_t v);
      half_period = v;
    endfunction

    // Advance the axis by one tick and queue the status word it produces.
    function void take_command(casc_pkg::in_item_t it);
      casc_pkg::result_t r;
      casc_pkg::status_t st;
      int                tgt;
      int                diff;
      st = casc_pkg::ST_NONE;
      case (it.command)
        casc_pkg::CMD_OFF: begin
          go_idle();
          drv_on = 1'b0;
        end
        casc_pkg::CMD_MOVE: begin
          tgt    = (it.target > casc_pkg::STEPS_PER_TURN - 1) ?
                   casc_pkg::STEPS_PER_TURN - 1 : int'(it.target);
          drv_on = 1'b1;
          if (pos < tgt) begin
            diff       = tgt - int'(pos);
            dir_cw     = (diff < casc_pkg::STEPS_PER_TURN / 2);
            steps_left = casc_pkg::cnt_t'(dir_cw ? diff : casc_pkg::STEPS_PER_TURN - diff);
          end else begin
            diff       = int'(pos) - tgt;
            dir_cw     = (diff >= casc_pkg::STEPS_PER_TURN / 2);
            steps_left = casc_pkg::cnt_t'(dir_cw ? casc_pkg::STEPS_PER_TURN - diff : diff);
          end
          if (steps_left == 0) begin
            go_idle();
            st = casc_pkg::ST_MOVE_DONE;
          end else begin
            mode = casc_pkg::MODE_MOVE;
            start_step();
          end
        end
        casc_pkg::CMD_HOME: begin
          if (it.end_switch) begin
            pos = '0;
            go_idle();
            st = casc_pkg::ST_HOME_OK;
          end else begin
            drv_on     = 1'b1;
            dir_cw     = 1'b0;
            steps_left = (pos > 0) ? casc_pkg::cnt_t'(pos + casc_pkg::HOME_OVERRUN) :
                                     casc_pkg::cnt_t'(casc_pkg::HOME_SEARCH_LIMIT);
            mode       = casc_pkg::MODE_HOME;
            start_step();
          end
        end
        default: begin
          if (mode != casc_pkg::MODE_IDLE) begin
            if (phase_timer > 0) phase_timer--;
            if (phase_timer == 0) begin
              if (pulse_hi) begin
                pulse_hi    = 1'b0;
                phase_timer = phase_len();
              end else begin
                // step complete: move one position, then decide what comes next
                if (dir_cw) begin
                  pos = (pos == casc_pkg::STEPS_PER_TURN - 1) ? casc_pkg::pos_t'(0) :
                                                                pos + 1'b1;
                end else begin
                  pos = (pos == 0) ? casc_pkg::pos_t'(casc_pkg::STEPS_PER_TURN - 1) :
                                     pos - 1'b1;
                end
                if (steps_left > 0) steps_left--;
                if (mode == casc_pkg::MODE_HOME && it.end_switch) begin
                  pos    = '0;
                  drv_on = 1'b0;
                  go_idle();
                  st = casc_pkg::ST_HOME_OK;
                end else if (steps_left == 0) begin
                  st = (mode == casc_pkg::MODE_HOME) ? casc_pkg::ST_HOME_FAIL :
                                                       casc_pkg::ST_MOVE_DONE;
                  go_idle();
                end else begin
                  start_step();
                end
              end
            end
          end
        end
      endcase
      r.step_out  = pulse_hi;
      r.dir_out   = dir_cw;
      r.driver_on = drv_on;
      r.position  = pos;
      r.busy_res  = (mode != casc_pkg::MODE_IDLE);
      r.status    = st;
      owed_q.push_back(r);
    endfunction

    function void field_check(string name, logic [casc_pkg::OUT_W-1:0] want,
                              logic [casc_pkg::OUT_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_output(logic [casc_pkg::OUT_W-1:0] data);
      casc_pkg::result_t got;
      casc_pkg::result_t want;
      got = casc_pkg::result_t'(data);
      checked++;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: status word %h arrived with nothing outstanding", $time, data);
        return;
      end
      want = owed_q.pop_front();
      field_check("step_out", want.step_out, got.step_out);
      field_check("dir_out", want.dir_out, got.dir_out);
      field_check("driver_on", want.driver_on, got.driver_on);
      field_check("position", want.position, got.position);
      field_check("busy_res", want.busy_res, got.busy_res);
      field_check("status", want.status, got.status);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [casc_pkg::IN_W-1:0]      s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [casc_pkg::OUT_W-1:0]     m_axis_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [casc_pkg::TIMER_W-1:0]   cfg_data = '0;

  axis_step_checker sb = new();

  int tx_burst = 0;
  int rx_burst = 0;
  int rx_hold  = 0;
  bit long_hold_done = 1'b0;

  circular_axis_stepper_controller dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic casc_pkg::in_item_t make_item(casc_pkg::cmd_t c, int tgt, bit sw);
    casc_pkg::in_item_t it;
    it.command    = c;
    it.target     = casc_pkg::pos_t'(tgt);
    it.end_switch = sw;
    return it;
  endfunction

  // mostly back-to-back, some short gaps, the odd long one
  function automatic int tx_gap();
    int r;
    if (tx_burst > 0) begin
      tx_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      tx_burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic rx_next();
    int r;
    // one long hold-off so the output fills and the input stalls
    if (!long_hold_done && sb.checked >= 600) begin
      long_hold_done = 1'b1;
      rx_hold = 300;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      return 1'b0;
    end
    if (rx_burst > 0) begin
      rx_burst--;
      return 1'b1;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      rx_burst = $urandom_range(20, 80);
      return 1'b1;
    end
    if (r < 60) return 1'b1;
    if (r < 92) begin
      rx_hold = $urandom_range(0, 2);
      return 1'b0;
    end
    rx_hold = $urandom_range(4, 25);
    return 1'b0;
  endfunction

  task automatic send_item(casc_pkg::in_item_t it);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, it};
    do @(posedge clk); while (!s_axis_tready);
    sb.take_command(it);
  endtask

  // register write only once the block has drained
  task automatic write_half_period(casc_pkg::timer_t v);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_half_period(v);
    cfg_valid <= 1'b0;
  endtask

  // Command followed by enough ticks to finish it, now and then cut short.
  task automatic run_random(int n);
    int sent;
    int r;
    int plen;
    int off;
    int need;
    int ticks;
    int close_at;
    int k;
    int lim;
    int cnt;
    bit homing;
    sent = 0;
    while (sent < n) begin
      plen     = (sb.half_period == 0) ? 1 : int'(sb.half_period);
      r        = $urandom_range(0, 99);
      homing   = 1'b0;
      close_at = 0;
      need     = 0;
      if (r < 45) begin
        off  = $urandom_range(0, 60) - 30;
        send_item(make_item(casc_pkg::CMD_MOVE,
                            (int'(sb.pos) + casc_pkg::STEPS_PER_TURN + off) %
                            casc_pkg::STEPS_PER_TURN,
                            $urandom_range(0, 1)));
        need = 2 * plen * ((off < 0) ? -off : off);
        sent++;
      end else if (r < 55) begin
        send_item(make_item(casc_pkg::CMD_MOVE, $urandom_range(0, 1023),
                            $urandom_range(0, 1)));
        need = 2 * plen * (casc_pkg::STEPS_PER_TURN / 2);
        sent++;
      end else if (r < 75) begin
        lim = (sb.pos > 0) ? int'(sb.pos) + casc_pkg::HOME_OVERRUN :
                             casc_pkg::HOME_SEARCH_LIMIT;
        // a quarter of searches never see the switch and run out
        k   = ($urandom_range(0, 3) == 0) ? lim + 1 : $urandom_range(1, 12);
        send_item(make_item(casc_pkg::CMD_HOME, $urandom_range(0, 1023), 1'b0));
        homing   = 1'b1;
        close_at = 2 * plen * k - 1;
        need     = 2 * plen * ((k < lim) ? k : lim);
        sent++;
      end else if (r < 82) begin
        send_item(make_item(casc_pkg::CMD_HOME, $urandom_range(0, 1023), 1'b1));
        sent++;
      end else if (r < 88) begin
        send_item(make_item(casc_pkg::CMD_OFF, $urandom_range(0, 1023),
                            $urandom_range(0, 1)));
        sent++;
      end else begin
        cnt = $urandom_range(1, 5);
        repeat (cnt) send_item(casc_pkg::in_item_t'($urandom_range(0, 16'h1fff)));
        sent += cnt;
      end
      ticks = need + $urandom_range(0, 3);
      if ($urandom_range(0, 7) == 0) ticks = $urandom_range(0, ticks);
      if (ticks > 200) ticks = 200;
      if (ticks > n - sent) ticks = (n > sent) ? n - sent : 0;
      for (int i = 0; i < ticks; i++) begin
        send_item(make_item(casc_pkg::CMD_TICK, $urandom_range(0, 1023),
                            homing ? (i >= close_at) : bit'($urandom_range(0, 1))));
      end
      sent += ticks;
    end
  endtask

  initial begin
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata);
      m_axis_tready <= rx_next();
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_half_period(16'd1);
    send_item(make_item(casc_pkg::CMD_TICK, 0, 1'b1));
    send_item(make_item(casc_pkg::CMD_MOVE, 3, 1'b0));
    repeat (6) send_item(make_item(casc_pkg::CMD_TICK, 512, 1'b0));
    // move to where the axis already is
    send_item(make_item(casc_pkg::CMD_MOVE, 3, 1'b1));
    // home with the switch already closed
    send_item(make_item(casc_pkg::CMD_HOME, 0, 1'b1));
    // out-of-range target clamps, one step backwards across zero
    send_item(make_item(casc_pkg::CMD_MOVE, 1023, 1'b0));
    repeat (2) send_item(make_item(casc_pkg::CMD_TICK, 0, 1'b0));
    send_item(make_item(casc_pkg::CMD_HOME, 0, 1'b0));
    repeat (3) send_item(make_item(casc_pkg::CMD_TICK, 0, 1'b0));
    send_item(make_item(casc_pkg::CMD_TICK, 0, 1'b1));
    // half a turn goes the other way round; then abort
    send_item(make_item(casc_pkg::CMD_MOVE, 400, 1'b0));
    send_item(make_item(casc_pkg::CMD_TICK, 0, 1'b0));
    send_item(make_item(casc_pkg::CMD_OFF, 0, 1'b0));
    // restart while homing
    send_item(make_item(casc_pkg::CMD_HOME, 0, 1'b0));
    repeat (2) send_item(make_item(casc_pkg::CMD_TICK, 0, 1'b0));
    send_item(make_item(casc_pkg::CMD_MOVE, 0, 1'b0));
    send_item(make_item(casc_pkg::CMD_TICK, 1023, 1'b1));

    run_random(700);
    write_half_period(16'd0);
    run_random(300);
    write_half_period(16'd3);
    run_random(350);
    write_half_period(casc_pkg::timer_t'($urandom_range(2, 6)));
    run_random(350);
    write_half_period(16'hFFFF);
    run_random(120);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
